// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define GTE_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gte check failed");

// next-cycle implication, masked during reset
`define GTE_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gte check failed");

// next-cycle implication, checked through reset
`define GTE_ASSERT_NXT_ANY(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("gte check failed");

`endif

// ----- src/gte_pkg.sv -----
// ----------------------------------------------------------------------------
// gte_pkg
// Constants, tables and shared types of the geodetic to ECEF converter.
// ----------------------------------------------------------------------------
package gte_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int NEWTON_STEPS = 4;

  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
  localparam logic [22:0]        E2_Q30        = 23'd7188036;
  localparam logic [29:0]        B2A2_Q30      = 30'd1066553788;
  localparam logic [32:0]        SEMI_MAJOR_MM = 33'd6378137000;
  localparam logic [38:0]        DIV45_RECIP   = 39'd390937467653;
  localparam logic [19:0]        HM_SCALE      = 20'd1000000;
  localparam logic [30:0]        Q30_ONE       = 31'd1073741824;

  localparam logic signed [31:0] LAT_LIMIT = 32'sd1509949440;
  localparam logic signed [33:0] ALT_LOW   = -34'sd65536000;
  localparam logic signed [33:0] ALT_HIGH  = 34'sd6553600000;

  localparam logic signed [32:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4, 33'sh028B0D43,
    33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55, 33'sh0028BE53, 33'sh00145F2F,
    33'sh000A2F98, 33'sh000517CC, 33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA,
    33'sh0000517D, 33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
    33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051, 33'sh00000029,
    33'sh00000014, 33'sh0000000A, 33'sh00000005, 33'sh00000003, 33'sh00000001
  };

  typedef struct packed {
    logic                vld;
    logic                flip_lat;
    logic                flip_lon;
    logic signed [32:0]  z_lat;
    logic signed [32:0]  z_lon;
    logic signed [37:0]  h;
  } cordic_in_t;

  typedef struct packed {
    logic                vld;
    logic signed [33:0]  cl;
    logic signed [33:0]  sl;
    logic signed [33:0]  cn;
    logic signed [33:0]  sn;
    logic signed [37:0]  h;
  } cordic_out_t;

endpackage

// ----- src/gte_if.sv -----
// ----------------------------------------------------------------------------
// gte_if
// Valid/ready channels for geodetic points and ECEF results.
// ----------------------------------------------------------------------------
interface gte_geo_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude;
  logic signed [32:0] longitude;
  logic signed [33:0] altitude;

  modport source (output valid, output latitude, output longitude, output altitude,
                  input ready);
  modport sink   (input valid, input latitude, input longitude, input altitude,
                  output ready);
endinterface

interface gte_ecef_if;
  logic               valid;
  logic               ready;
  logic signed [37:0] ecef_x;
  logic signed [37:0] ecef_y;
  logic signed [37:0] ecef_z;

  modport source (output valid, output ecef_x, output ecef_y, output ecef_z,
                  input ready);
  modport sink   (input valid, input ecef_x, input ecef_y, input ecef_z,
                  output ready);
endinterface

// ----- src/gte_cordic.sv -----
// ----------------------------------------------------------------------------
// gte_cordic
// Two-lane rotation CORDIC, one step per stage, for latitude and longitude.
// ----------------------------------------------------------------------------
module gte_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  gte_pkg::cordic_in_t  cin,
  output gte_pkg::cordic_out_t cout
);

  typedef struct packed {
    logic               vld;
    logic               flip_lat;
    logic               flip_lon;
    logic signed [33:0] xa;
    logic signed [33:0] ya;
    logic signed [32:0] za;
    logic signed [33:0] xo;
    logic signed [33:0] yo;
    logic signed [32:0] zo;
    logic signed [37:0] h;
  } cst_t;

  cst_t st [0:gte_pkg::CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (adv) begin
      st[0].vld <= cin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].flip_lat <= cin.flip_lat;
      st[0].flip_lon <= cin.flip_lon;
      st[0].xa       <= gte_pkg::CORDIC_GAIN;
      st[0].ya       <= '0;
      st[0].za       <= cin.z_lat;
      st[0].xo       <= gte_pkg::CORDIC_GAIN;
      st[0].yo       <= '0;
      st[0].zo       <= cin.z_lon;
      st[0].h        <= cin.h;
    end
  end

  for (genvar i = 0; i < gte_pkg::CORDIC_STEPS; i++) begin : g_step
    cst_t nx;

    always_comb begin
      nx = st[i];
      if (st[i].za >= 0) begin
        nx.xa = st[i].xa - (st[i].ya >>> i);
        nx.ya = st[i].ya + (st[i].xa >>> i);
        nx.za = st[i].za - gte_pkg::ATAN_TURN[i];
      end else begin
        nx.xa = st[i].xa + (st[i].ya >>> i);
        nx.ya = st[i].ya - (st[i].xa >>> i);
        nx.za = st[i].za + gte_pkg::ATAN_TURN[i];
      end
      if (st[i].zo >= 0) begin
        nx.xo = st[i].xo - (st[i].yo >>> i);
        nx.yo = st[i].yo + (st[i].xo >>> i);
        nx.zo = st[i].zo - gte_pkg::ATAN_TURN[i];
      end else begin
        nx.xo = st[i].xo + (st[i].yo >>> i);
        nx.yo = st[i].yo - (st[i].xo >>> i);
        nx.zo = st[i].zo + gte_pkg::ATAN_TURN[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].vld <= 1'b0;
      end else if (adv) begin
        st[i+1] <= nx;
      end
    end
  end

  always_comb begin
    cout.vld = st[gte_pkg::CORDIC_STEPS].vld;
    cout.cl  = st[gte_pkg::CORDIC_STEPS].flip_lat ? -st[gte_pkg::CORDIC_STEPS].xa
                                                  :  st[gte_pkg::CORDIC_STEPS].xa;
    cout.sl  = st[gte_pkg::CORDIC_STEPS].flip_lat ? -st[gte_pkg::CORDIC_STEPS].ya
                                                  :  st[gte_pkg::CORDIC_STEPS].ya;
    cout.cn  = st[gte_pkg::CORDIC_STEPS].flip_lon ? -st[gte_pkg::CORDIC_STEPS].xo
                                                  :  st[gte_pkg::CORDIC_STEPS].xo;
    cout.sn  = st[gte_pkg::CORDIC_STEPS].flip_lon ? -st[gte_pkg::CORDIC_STEPS].yo
                                                  :  st[gte_pkg::CORDIC_STEPS].yo;
    cout.h   = st[gte_pkg::CORDIC_STEPS].h;
  end

endmodule

// ----- src/geodetic_to_ecef.sv -----
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// WGS84 geodetic point to Earth-centred Earth-fixed coordinates in mm.
// ----------------------------------------------------------------------------
// Channels: geo takes one word per point (latitude, longitude in degrees
// times 2^24, altitude in km times 2^16); ecef gives one word per point
// with x, y and z in signed millimetres. Both use valid/ready.
// Throughput: one word per cycle while ecef is not stalled. The pipeline
// has 54 register stages: 3 angle conversion, 31 CORDIC, 2 for sin^2 and
// 1-e2 sin^2, 12 for four Newton reciprocal square root steps, 2 for N
// and N+h, and 4 for the rounded Q30 products in two rounds.
// The whole pipeline advances when the output register is empty or taken;
// while ecef is stalled with a word waiting, every stage holds and
// geo.ready is low, so nothing is lost or repeated.
// Reset clears all stage valid bits; no word is in flight afterwards.
// Out-of-range latitude and altitude saturate, longitude wraps.
// ----------------------------------------------------------------------------
module geodetic_to_ecef (
  input  logic              clk,
  input  logic              rst,
  gte_geo_if.sink           geo,
  gte_ecef_if.source        ecef
);

  typedef struct packed {
    logic signed [33:0] cl;
    logic signed [33:0] sl;
    logic signed [33:0] cn;
    logic signed [33:0] sn;
    logic signed [37:0] h;
  } side_t;

  typedef struct packed {
    logic        vld;
    logic [30:0] w;
    logic [31:0] r;
    logic [31:0] tv;
    side_t       sd;
  } nwt_t;

  typedef struct packed {
    logic        flip;
    logic signed [32:0] z;
  } ang_t;

  typedef struct packed {
    logic        neg;
    logic [50:0] hi;
    logic [52:0] lo;
  } pp_t;

  function automatic logic [32:0] div_q0(input logic [57:0] hi, input logic [57:0] lo);
    logic [77:0] s;
    s = {1'b0, hi, 19'b0} + {20'b0, lo};
    return s[76:44];
  endfunction

  function automatic ang_t to_angle(input logic [37:0] v, input logic [32:0] q0,
                                    input logic neg);
    logic [37:0]        rem;
    logic [32:0]        q;
    logic signed [31:0] t;
    logic signed [32:0] te;
    ang_t               a;
    rem = v - 38'(q0) * 38'd45;
    q   = q0 + 33'(rem >= 38'd45);
    t   = neg ? $signed(32'(33'd0 - q)) : $signed(q[31:0]);
    te  = 33'(t);
    if (te > 33'sd1073741824) begin
      a.flip = 1'b1;
      a.z    = te - 33'sd2147483648;
    end else if (te < -33'sd1073741824) begin
      a.flip = 1'b1;
      a.z    = te + 33'sd2147483648;
    end else begin
      a.flip = 1'b0;
      a.z    = te;
    end
    return a;
  endfunction

  function automatic pp_t q30_pp(input logic signed [38:0] a, input logic signed [33:0] b);
    logic [38:0] ua;
    logic [33:0] ub;
    pp_t         p;
    ua    = a[38] ? 39'(-a) : 39'(a);
    ub    = b[33] ? 34'(-b) : 34'(b);
    p.neg = a[38] ^ b[33];
    p.hi  = 51'(ua[37:20]) * 51'(ub[32:0]);
    p.lo  = 53'(ua[19:0]) * 53'(ub[32:0]);
    return p;
  endfunction

  function automatic logic signed [38:0] q30_fin(input pp_t p);
    logic [71:0] s;
    logic [38:0] r;
    s = {1'b0, p.hi, 20'b0} + {19'b0, p.lo} + 72'd536870912;
    r = s[68:30];
    return p.neg ? -$signed(r) : $signed(r);
  endfunction

  logic adv;
  logic q4_vld;

  assign adv       = !q4_vld || ecef.ready;
  assign geo.ready = adv;

  // input conditioning
  logic signed [31:0] lat_sat;
  logic signed [33:0] alt_sat;
  logic [31:0]        lat_mag;
  logic [32:0]        lon_mag;
  logic [32:0]        alt_mag;
  logic [52:0]        hm_full;
  logic [36:0]        hm;

  always_comb begin
    lat_sat = geo.latitude;
    if (geo.latitude > gte_pkg::LAT_LIMIT) lat_sat = gte_pkg::LAT_LIMIT;
    if (geo.latitude < -gte_pkg::LAT_LIMIT) lat_sat = -gte_pkg::LAT_LIMIT;
    alt_sat = geo.altitude;
    if (geo.altitude > gte_pkg::ALT_HIGH) alt_sat = gte_pkg::ALT_HIGH;
    if (geo.altitude < gte_pkg::ALT_LOW) alt_sat = gte_pkg::ALT_LOW;
    lat_mag = lat_sat[31] ? 32'(-lat_sat) : 32'(lat_sat);
    lon_mag = geo.longitude[32] ? (33'd0 - 33'(geo.longitude)) : 33'(geo.longitude);
    alt_mag = alt_sat[33] ? 33'(-alt_sat) : 33'(alt_sat);
    hm_full = 53'(alt_mag) * 53'(gte_pkg::HM_SCALE) + 53'd32768;
    hm      = hm_full[52:16];
  end

  // stage 1
  logic               p1_vld;
  logic [37:0]        p1_vlat, p1_vlon;
  logic               p1_nlat, p1_nlon;
  logic signed [37:0] p1_h;

  // stage 2
  logic               p2_vld;
  logic [57:0]        p2_hlat, p2_llat, p2_hlon, p2_llon;
  logic [37:0]        p2_vlat, p2_vlon;
  logic               p2_nlat, p2_nlon;
  logic signed [37:0] p2_h;

  // stage 3
  logic               p3_vld;
  logic [32:0]        p3_qlat, p3_qlon;
  logic [37:0]        p3_vlat, p3_vlon;
  logic               p3_nlat, p3_nlon;
  logic signed [37:0] p3_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= geo.valid;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_vlat <= {1'b0, lat_mag, 5'b0} + 38'd22;
      p1_vlon <= {lon_mag, 5'b0} + 38'd22;
      p1_nlat <= lat_sat[31];
      p1_nlon <= geo.longitude[32];
      p1_h    <= alt_sat[33] ? -$signed({1'b0, hm}) : $signed({1'b0, hm});

      p2_hlat <= 58'(p1_vlat[37:19]) * 58'(gte_pkg::DIV45_RECIP);
      p2_llat <= 58'(p1_vlat[18:0]) * 58'(gte_pkg::DIV45_RECIP);
      p2_hlon <= 58'(p1_vlon[37:19]) * 58'(gte_pkg::DIV45_RECIP);
      p2_llon <= 58'(p1_vlon[18:0]) * 58'(gte_pkg::DIV45_RECIP);
      p2_vlat <= p1_vlat;
      p2_vlon <= p1_vlon;
      p2_nlat <= p1_nlat;
      p2_nlon <= p1_nlon;
      p2_h    <= p1_h;

      p3_qlat <= div_q0(p2_hlat, p2_llat);
      p3_qlon <= div_q0(p2_hlon, p2_llon);
      p3_vlat <= p2_vlat;
      p3_vlon <= p2_vlon;
      p3_nlat <= p2_nlat;
      p3_nlon <= p2_nlon;
      p3_h    <= p2_h;
    end
  end

  // CORDIC
  gte_pkg::cordic_in_t  cin;
  gte_pkg::cordic_out_t cout;
  ang_t                 a_lat, a_lon;

  always_comb begin
    a_lat        = to_angle(p3_vlat, p3_qlat, p3_nlat);
    a_lon        = to_angle(p3_vlon, p3_qlon, p3_nlon);
    cin.vld      = p3_vld;
    cin.flip_lat = a_lat.flip;
    cin.flip_lon = a_lon.flip;
    cin.z_lat    = a_lat.z;
    cin.z_lon    = a_lon.z;
    cin.h        = p3_h;
  end

  gte_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .cin  (cin),
    .cout (cout)
  );

  // sin^2 and 1 - e2 sin^2
  logic        a5_vld, a6_vld;
  logic [31:0] a5_s2;
  side_t       a5_sd, a6_sd;
  logic [30:0] a6_w;
  logic [31:0] sl_mag;
  logic [63:0] sq;
  logic [63:0] e2p;

  always_comb begin
    sl_mag = 32'(cout.sl[33] ? -cout.sl : cout.sl);
    sq     = 64'(sl_mag) * 64'(sl_mag);
    e2p    = 64'(gte_pkg::E2_Q30) * 64'(a5_s2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a5_vld <= 1'b0;
      a6_vld <= 1'b0;
    end else if (adv) begin
      a5_vld <= cout.vld;
      a6_vld <= a5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a5_s2    <= sq[61:30];
      a5_sd.cl <= cout.cl;
      a5_sd.sl <= cout.sl;
      a5_sd.cn <= cout.cn;
      a5_sd.sn <= cout.sn;
      a5_sd.h  <= cout.h;
      a6_w     <= gte_pkg::Q30_ONE - e2p[60:30];
      a6_sd    <= a5_sd;
    end
  end

  // Newton steps for 1/sqrt(w)
  nwt_t nw [0:3*gte_pkg::NEWTON_STEPS];

  always_comb begin
    nw[0].vld = a6_vld;
    nw[0].w   = a6_w;
    nw[0].r   = 32'(gte_pkg::Q30_ONE);
    nw[0].tv  = '0;
    nw[0].sd  = a6_sd;
  end

  for (genvar j = 0; j < 3*gte_pkg::NEWTON_STEPS; j++) begin : g_nwt
    nwt_t        nx;
    logic [63:0] p;

    if (j % 3 == 0) begin : g_sq
      always_comb begin
        nx    = nw[j];
        p     = 64'(nw[j].r) * 64'(nw[j].r);
        nx.tv = p[61:30];
      end
    end else if (j % 3 == 1) begin : g_wt
      always_comb begin
        nx    = nw[j];
        p     = 64'(nw[j].w) * 64'(nw[j].tv);
        nx.tv = 32'(34'd3221225472 - p[63:30]);
      end
    end else begin : g_rv
      always_comb begin
        nx   = nw[j];
        p    = 64'(nw[j].r) * 64'(nw[j].tv);
        nx.r = p[62:31];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nw[j+1].vld <= 1'b0;
      end else if (adv) begin
        nw[j+1] <= nx;
      end
    end
  end

  // N, N + h and (b^2/a^2) N + h
  logic               n_vld, m_vld;
  logic [32:0]        n_n;
  side_t              n_sd;
  logic signed [38:0] m_nh, m_zr;
  side_t              m_sd;
  logic [65:0]        na;
  logic [63:0]        zp;

  always_comb begin
    na = 66'(gte_pkg::SEMI_MAJOR_MM) * 66'(nw[3*gte_pkg::NEWTON_STEPS].r) + 66'd536870912;
    zp = 64'(n_n) * 64'(gte_pkg::B2A2_Q30) + 64'd536870912;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
      m_vld <= 1'b0;
    end else if (adv) begin
      n_vld <= nw[3*gte_pkg::NEWTON_STEPS].vld;
      m_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_n  <= na[62:30];
      n_sd <= nw[3*gte_pkg::NEWTON_STEPS].sd;
      m_nh <= $signed({6'b0, n_n}) + 39'(n_sd.h);
      m_zr <= $signed({6'b0, zp[62:30]}) + 39'(n_sd.h);
      m_sd <= n_sd;
    end
  end

  // rounded Q30 products
  logic               q1_vld, q2_vld, q3_vld;
  pp_t                q1_pp;
  logic signed [38:0] q1_zr, q2_zr, q2_rad;
  logic signed [33:0] q1_sl, q1_cn, q1_sn, q2_sl, q2_cn, q2_sn;
  pp_t                q3_px, q3_py, q3_pz;
  logic signed [37:0] q4_x, q4_y, q4_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
      q2_vld <= 1'b0;
      q3_vld <= 1'b0;
      q4_vld <= 1'b0;
    end else if (adv) begin
      q1_vld <= m_vld;
      q2_vld <= q1_vld;
      q3_vld <= q2_vld;
      q4_vld <= q3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_pp  <= q30_pp(m_nh, m_sd.cl);
      q1_zr  <= m_zr;
      q1_sl  <= m_sd.sl;
      q1_cn  <= m_sd.cn;
      q1_sn  <= m_sd.sn;

      q2_rad <= q30_fin(q1_pp);
      q2_zr  <= q1_zr;
      q2_sl  <= q1_sl;
      q2_cn  <= q1_cn;
      q2_sn  <= q1_sn;

      q3_px  <= q30_pp(q2_rad, q2_cn);
      q3_py  <= q30_pp(q2_rad, q2_sn);
      q3_pz  <= q30_pp(q2_zr, q2_sl);

      q4_x   <= 38'(q30_fin(q3_px));
      q4_y   <= 38'(q30_fin(q3_py));
      q4_z   <= 38'(q30_fin(q3_pz));
    end
  end

  assign ecef.valid  = q4_vld;
  assign ecef.ecef_x = q4_x;
  assign ecef.ecef_y = q4_y;
  assign ecef.ecef_z = q4_z;

endmodule

// ----- src/gte_checker.sv -----
// ----------------------------------------------------------------------------
// gte_checker
// Port-level checks of the converter's flow control, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gte_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [37:0] x,
  input logic [37:0] y,
  input logic [37:0] z
);

  `GTE_ASSERT_IMP(a_ready_follows_out, 1'b1, in_ready == (!out_valid || out_ready))
  `GTE_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable({x, y, z}))
  `GTE_ASSERT_NXT(a_blocked_keeps_word, !in_ready, out_valid)
  `GTE_ASSERT_NXT_ANY(a_reset_empties, rst, !out_valid)

endmodule

bind geodetic_to_ecef gte_checker u_gte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (geo.ready),
  .out_valid (ecef.valid),
  .out_ready (ecef.ready),
  .x         (ecef.ecef_x),
  .y         (ecef.ecef_y),
  .z         (ecef.ecef_z)
);
